// ===== rtl/radix_four_bucket_switch_top_macros.svh =====
// Assertion macros shared by the switch RTL.
// Depends on nothing; included by files that assert.
`ifndef RADIX_FOUR_BUCKET_SWITCH_TOP_MACROS_SVH
`define RADIX_FOUR_BUCKET_SWITCH_TOP_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define RFBS_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define RFBS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== rtl/rfbs_pkg.sv =====
// Types and codes for the radix-four bucket switch.
// Depends on nothing.
package rfbs_pkg;
    localparam logic [2:0] KIND_IDLE     = 3'd0;
    localparam logic [2:0] KIND_DELIVER  = 3'd1;
    localparam logic [2:0] KIND_END      = 3'd2;
    localparam logic [2:0] KIND_QUEUED   = 3'd3;
    localparam logic [2:0] KIND_HELD     = 3'd4;
    localparam logic [2:0] KIND_REJECT   = 3'd5;
    localparam logic [2:0] KIND_FINISHED = 3'd6;
    localparam logic       CMD_ARRIVE    = 1'b0;
    localparam logic       CMD_TICK      = 1'b1;
    localparam int         REG_DIGIT_SELECT = 0;

    typedef struct packed {
        logic [2:0]  kind;
        logic [1:0]  port;
        logic [31:0] index;
        logic [31:0] value;
        logic        last;
    } result_t;
endpackage

// ===== rtl/rfbs_out_fifo.sv =====
// Result FIFO parting the switch core from the result channel.
// Depends on rfbs_pkg.
module rfbs_out_fifo #(
    parameter int DEPTH = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                wr_en,
    input  rfbs_pkg::result_t   wr_data,
    output logic [$clog2(DEPTH+1)-1:0] fill,
    output logic                rd_valid,
    input  logic                rd_ready,
    output rfbs_pkg::result_t   rd_data
);
    localparam int AW = $clog2(DEPTH);
    rfbs_pkg::result_t mem [DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [$clog2(DEPTH+1)-1:0] cnt_reg;
    logic rd;

    assign rd = rd_valid && rd_ready;
    assign rd_valid = cnt_reg != '0;
    assign rd_data = mem[rp_reg];
    assign fill = cnt_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wp_reg] <= wr_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (wr_en) wp_reg <= (wp_reg == AW'(DEPTH-1)) ? '0 : wp_reg + 1'b1;
            if (rd) rp_reg <= (rp_reg == AW'(DEPTH-1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (wr_en ? 1'b1 : 1'b0) - (rd ? 1'b1 : 1'b0);
        end
    end
endmodule

// ===== rtl/radix_four_bucket_switch_top.sv =====
// Top level of the radix-four bucket switch: queue memory, control, APB port.
// Depends on rfbs_pkg, rfbs_out_fifo and the macros header.
//
// Sixteen per-(destination, source) queues share one synchronous memory with
// one write and one registered read per cycle; pointers, fill counts, hold
// slots and the priority counter are registers. An arrival or an idle tick
// leaves the switch idle, and arrivals can follow back to back. A delivery tick
// updates all pointers when accepted, then reads its pops one port per cycle
// (steps 0..3) and writes retried held packets one source per cycle (steps
// 3..6, from the last read step on); the input waits until its steps are done. An
// end-marker tick sends its four markers in steps 0..3, while the input waits.
// Results go through an eight-entry FIFO; an item is taken only while at
// least four slots are free, so a stalled result side stalls the input.
`include "radix_four_bucket_switch_top_macros.svh"
module radix_four_bucket_switch_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_cmd,
    input  logic [1:0]  s_src_port,
    input  logic [31:0] s_pkt_index,
    input  logic [31:0] s_pkt_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_out_kind,
    output logic [1:0]  m_out_port,
    output logic [31:0] m_out_index,
    output logic [31:0] m_out_value,
    output logic        m_last
);
    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam int MD = 16 * QUEUE_DEPTH;
    localparam int AW = $clog2(MD);

    logic [3:0] ds_reg;
    logic [63:0] store [MD];
    logic [63:0] rdata_reg;
    logic [QW-1:0] rp_reg [16], rp_next [16], wp_reg [16], wp_next [16];
    logic [FW-1:0] fl_reg [16], fl_next [16];
    logic [3:0] hv_reg, hv_next, sf_reg, sf_next;
    logic [63:0] he_reg [4], he_next [4];
    logic [1:0] pc_reg, pc_next;
    logic [15:0] push;
    logic all_done;
    logic arr_push;
    logic [AW-1:0] arr_addr;
    logic [3:0] pop_v, psh_v;
    logic [AW-1:0] pop_a [4], psh_a [4];
    logic [2:0] end_ph;
    logic [1:0] last_port;
    logic imm_v;
    rfbs_pkg::result_t imm_res;
    logic [3:0] ofill;
    logic acc;

    logic busy_reg, end_mode_reg, rd_pend_reg;
    logic [2:0] ph_reg, end_ph_reg;
    logic [3:0] pop_v_reg, psh_v_reg;
    logic [AW-1:0] pop_a_reg [4], psh_a_reg [4];
    logic [1:0] last_port_reg, rd_port_reg;
    logic rd_last_reg;
    logic rd_en, eng_we;
    logic [2:0] wr_sel;

    assign pready = 1'b1;
    assign prdata = {28'd0, ds_reg};
    always_ff @(posedge aclk) begin
        if (!aresetn) ds_reg <= '0;
        else if (psel && penable && pwrite && paddr == 2'(4 * rfbs_pkg::REG_DIGIT_SELECT))
            ds_reg <= pwdata[3:0];
    end

    assign s_ready = !busy_reg && !rd_pend_reg && (ofill <= 4'd4);
    assign acc = s_valid && s_ready;

    function automatic logic [1:0] dest(input logic [31:0] idx, input logic [3:0] ds);
        logic [63:0] w;
        w = {32'd0, idx} >> {ds, 1'b0};
        return w[1:0];
    endfunction

    function automatic logic [QW-1:0] inc(input logic [QW-1:0] p);
        return (p == QW'(QUEUE_DEPTH-1)) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        logic found;
        logic [3:0] q;
        logic [1:0] d, src;
        found = 1'b0;
        q = '0;
        d = '0;
        src = '0;
        rp_next = rp_reg; wp_next = wp_reg; fl_next = fl_reg;
        hv_next = hv_reg; sf_next = sf_reg; he_next = he_reg; pc_next = pc_reg;
        push = '0;
        pop_v = '0;
        psh_v = '0;
        for (int k = 0; k < 4; k++) begin
            pop_a[k] = '0;
            psh_a[k] = '0;
        end
        imm_v = 1'b0;
        imm_res = '0;
        arr_push = 1'b0;
        arr_addr = '0;
        end_ph = '0;
        last_port = '0;
        all_done = (sf_reg == 4'hf) && (hv_reg == 4'h0);
        for (int k = 0; k < 16; k++) if (fl_reg[k] != '0) all_done = 1'b0;
        if (s_cmd == rfbs_pkg::CMD_ARRIVE) begin
            imm_v = 1'b1;
            imm_res.last = 1'b1;
            d = dest(s_pkt_index, ds_reg);
            q = {d, s_src_port};
            if (hv_reg[s_src_port] || sf_reg[s_src_port]) begin
                imm_res.kind = rfbs_pkg::KIND_REJECT;
            end else if (s_pkt_value == '0) begin
                sf_next[s_src_port] = 1'b1;
                imm_res.kind = rfbs_pkg::KIND_FINISHED;
            end else if (fl_reg[q] < FW'(QUEUE_DEPTH)) begin
                push[q] = 1'b1;
                arr_push = 1'b1;
                arr_addr = AW'(int'(q) * QUEUE_DEPTH + int'(wp_reg[q]));
                imm_res.kind = rfbs_pkg::KIND_QUEUED;
                imm_res.port = d;
            end else begin
                hv_next[s_src_port] = 1'b1;
                he_next[s_src_port] = {s_pkt_index, s_pkt_value};
                imm_res.kind = rfbs_pkg::KIND_HELD;
                imm_res.port = d;
            end
        end else if (all_done) begin
            end_ph = 3'd3;
            sf_next = '0;
            pc_next = '0;
        end else begin
            for (int p = 0; p < 4; p++) begin
                found = 1'b0;
                for (int i = 0; i < 4; i++) begin
                    src = pc_reg ^ 2'(i);
                    q = {2'(p), src};
                    if (!found && fl_reg[q] != '0) begin
                        found = 1'b1;
                        pop_v[p] = 1'b1;
                        pop_a[p] = AW'(int'(q) * QUEUE_DEPTH + int'(rp_reg[q]));
                        last_port = 2'(p);
                        end_ph = 3'(p);
                        rp_next[q] = inc(rp_reg[q]);
                        fl_next[q] = fl_reg[q] - 1'b1;
                    end
                end
            end
            pc_next = pc_reg + 1'b1;
            for (int s = 0; s < 4; s++) begin
                if (hv_reg[s]) begin
                    q = {dest(he_reg[s][63:32], ds_reg), 2'(s)};
                    if (fl_next[q] < FW'(QUEUE_DEPTH)) begin
                        push[q] = 1'b1;
                        psh_v[s] = 1'b1;
                        psh_a[s] = AW'(int'(q) * QUEUE_DEPTH + int'(wp_reg[q]));
                        end_ph = 3'(s + 3);
                        hv_next[s] = 1'b0;
                    end
                end
            end
            if (pop_v == '0) begin
                imm_v = 1'b1;
                imm_res.kind = rfbs_pkg::KIND_IDLE;
                imm_res.last = 1'b1;
            end
        end
        for (int k = 0; k < 16; k++) begin
            if (push[k]) begin
                wp_next[k] = inc(wp_reg[k]);
                fl_next[k] = fl_next[k] + 1'b1;
            end
        end
    end

    assign wr_sel = ph_reg - 3'd3;
    assign rd_en = busy_reg && !end_mode_reg && (ph_reg < 3'd4) && pop_v_reg[ph_reg[1:0]];
    assign eng_we = busy_reg && !end_mode_reg && (ph_reg >= 3'd3) && psh_v_reg[wr_sel[1:0]];

    always_ff @(posedge aclk) begin
        if (acc && arr_push) store[arr_addr] <= {s_pkt_index, s_pkt_value};
        else if (eng_we) store[psh_a_reg[wr_sel[1:0]]] <= he_reg[wr_sel[1:0]];
        if (rd_en) rdata_reg <= store[pop_a_reg[ph_reg[1:0]]];
        if (acc) he_reg <= he_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 16; k++) begin
                rp_reg[k] <= '0; wp_reg[k] <= '0; fl_reg[k] <= '0;
            end
            hv_reg <= '0; sf_reg <= '0; pc_reg <= '0;
        end else if (acc) begin
            rp_reg <= rp_next; wp_reg <= wp_next; fl_reg <= fl_next;
            hv_reg <= hv_next; sf_reg <= sf_next; pc_reg <= pc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            end_mode_reg <= 1'b0;
            ph_reg <= '0;
            end_ph_reg <= '0;
            rd_pend_reg <= 1'b0;
        end else begin
            rd_pend_reg <= rd_en;
            if (acc && s_cmd == rfbs_pkg::CMD_TICK && (all_done || pop_v != '0)) begin
                busy_reg <= 1'b1;
                end_mode_reg <= all_done;
                ph_reg <= '0;
                end_ph_reg <= end_ph;
            end else if (busy_reg) begin
                if (ph_reg == end_ph_reg) busy_reg <= 1'b0;
                else ph_reg <= ph_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            pop_v_reg <= pop_v;
            pop_a_reg <= pop_a;
            psh_v_reg <= psh_v;
            psh_a_reg <= psh_a;
            last_port_reg <= last_port;
        end
        if (rd_en) begin
            rd_port_reg <= ph_reg[1:0];
            rd_last_reg <= ph_reg[1:0] == last_port_reg;
        end
    end

    rfbs_pkg::result_t wdata;
    rfbs_pkg::result_t m_res;
    logic wen;

    always_comb begin
        wen = 1'b0;
        wdata = '0;
        if (acc && imm_v) begin
            wen = 1'b1;
            wdata = imm_res;
        end else if (busy_reg && end_mode_reg) begin
            wen = 1'b1;
            wdata.kind = rfbs_pkg::KIND_END;
            wdata.port = ph_reg[1:0];
            wdata.last = ph_reg == 3'd3;
        end else if (rd_pend_reg) begin
            wen = 1'b1;
            wdata.kind = rfbs_pkg::KIND_DELIVER;
            wdata.port = rd_port_reg;
            wdata.index = rdata_reg[63:32];
            wdata.value = rdata_reg[31:0];
            wdata.last = rd_last_reg;
        end
    end

    rfbs_out_fifo #(.DEPTH(8)) u_fifo (
        .aclk(aclk), .aresetn(aresetn), .wr_en(wen), .wr_data(wdata),
        .fill(ofill), .rd_valid(m_valid), .rd_ready(m_ready), .rd_data(m_res)
    );
    assign m_out_kind = m_res.kind;
    assign m_out_port = m_res.port;
    assign m_out_index = m_res.index;
    assign m_out_value = m_res.value;
    assign m_last = m_res.last;

    `RFBS_ASSERT_IMPL(a_fifo_room, aclk, aresetn, wen, ofill < 4'd8)
    `RFBS_ASSERT_IMPL(a_busy_blocks, aclk, aresetn, busy_reg, !s_ready)
    `RFBS_ASSERT_IMPL(a_one_write, aclk, aresetn, eng_we, !(acc && arr_push))
    `RFBS_ASSERT_NEXT(a_end_clears, aclk, aresetn,
        acc && s_cmd == rfbs_pkg::CMD_TICK && all_done,
        pc_reg == 2'd0 && sf_reg == 4'h0)
endmodule

// ===== bench/tb_radix_four_bucket_switch_top.sv =====
// Testbench for the radix-four bucket switch: drives packets and delivery ticks over
// valid/ready, checks every result against a built-in switch predictor.
// Depends on rfbs_pkg and radix_four_bucket_switch_top.
`timescale 1ns / 100ps
module tb_radix_four_bucket_switch_top;

    class switch_scoreboard;
        bit [31:0] q_idx[16][4];
        bit [31:0] q_val[16][4];
        bit [1:0]  rd_ptr[16];
        bit [1:0]  wr_ptr[16];
        int        fill[16];
        bit        held[4];
        bit [31:0] held_idx[4];
        bit [31:0] held_val[4];
        bit        finished[4];
        bit [1:0]  prio;
        bit [3:0]  digit_sel;
        rfbs_pkg::result_t expected_results[$];
        int        errors;
        int        n_items;
        int        n_delivered;
        int        n_end_markers;
        int        n_held;
        int        n_rejected;

        function bit [1:0] dest_port(bit [31:0] idx);
            bit [31:0] sh;
            sh = idx >> {digit_sel, 1'b0};
            return sh[1:0];
        endfunction

        function void push_packet(int q, bit [31:0] idx, bit [31:0] val);
            q_idx[q][wr_ptr[q]] = idx;
            q_val[q][wr_ptr[q]] = val;
            wr_ptr[q]++;
            fill[q]++;
        endfunction

        function rfbs_pkg::result_t make_result(logic [2:0] kind, bit [1:0] port,
                                                bit [31:0] idx, bit [31:0] val);
            rfbs_pkg::result_t r;
            r.kind  = kind;
            r.port  = port;
            r.index = idx;
            r.value = val;
            r.last  = 1'b0;
            return r;
        endfunction

        function void note_item(bit cmd, bit [1:0] src, bit [31:0] idx, bit [31:0] val);
            rfbs_pkg::result_t step_out[$];
            bit      all_done;
            bit [1:0] d;
            int      q;
            n_items++;
            if (cmd == rfbs_pkg::CMD_ARRIVE) begin
                if (held[src] || finished[src]) begin
                    step_out.push_back(make_result(rfbs_pkg::KIND_REJECT, 2'd0, 32'd0, 32'd0));
                    n_rejected++;
                end else if (val == 0) begin
                    finished[src] = 1;
                    step_out.push_back(make_result(rfbs_pkg::KIND_FINISHED, 2'd0, 32'd0,
                                                   32'd0));
                end else begin
                    d = dest_port(idx);
                    q = d * 4 + src;
                    if (fill[q] < 4) begin
                        push_packet(q, idx, val);
                        step_out.push_back(make_result(rfbs_pkg::KIND_QUEUED, d, 32'd0, 32'd0));
                    end else begin
                        held[src] = 1;
                        held_idx[src] = idx;
                        held_val[src] = val;
                        step_out.push_back(make_result(rfbs_pkg::KIND_HELD, d, 32'd0, 32'd0));
                        n_held++;
                    end
                end
            end else begin
                all_done = 1;
                for (int s = 0; s < 4; s++)
                    if (!finished[s] || held[s]) all_done = 0;
                for (int i = 0; i < 16; i++)
                    if (fill[i] != 0) all_done = 0;
                if (all_done) begin
                    for (int p = 0; p < 4; p++)
                        step_out.push_back(make_result(rfbs_pkg::KIND_END, 2'(p), 32'd0, 32'd0));
                    for (int s = 0; s < 4; s++) finished[s] = 0;
                    prio = 0;
                    n_end_markers++;
                end else begin
                    for (int p = 0; p < 4; p++) begin
                        for (int i = 0; i < 4; i++) begin
                            q = p * 4 + (prio ^ i[1:0]);
                            if (fill[q] != 0) begin
                                step_out.push_back(make_result(rfbs_pkg::KIND_DELIVER, 2'(p),
                                    q_idx[q][rd_ptr[q]], q_val[q][rd_ptr[q]]));
                                rd_ptr[q]++;
                                fill[q]--;
                                n_delivered++;
                                break;
                            end
                        end
                    end
                    prio++;
                    for (int s = 0; s < 4; s++) begin
                        if (held[s]) begin
                            q = dest_port(held_idx[s]) * 4 + s;
                            if (fill[q] < 4) begin
                                push_packet(q, held_idx[s], held_val[s]);
                                held[s] = 0;
                            end
                        end
                    end
                    if (step_out.size() == 0)
                        step_out.push_back(make_result(rfbs_pkg::KIND_IDLE, 2'd0, 32'd0, 32'd0));
                end
            end
            step_out[step_out.size() - 1].last = 1'b1;
            foreach (step_out[k]) expected_results.push_back(step_out[k]);
        endfunction

        function void check_result(rfbs_pkg::result_t got);
            rfbs_pkg::result_t want;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result kind=%0d port=%0d index=%h value=%h",
                         $time, got.kind, got.port, got.index, got.value);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            if (got.kind != want.kind) begin
                $display("%0t: kind expected %0d actual %0d", $time, want.kind, got.kind);
                errors++;
            end
            if (got.port != want.port) begin
                $display("%0t: port expected %0d actual %0d", $time, want.port, got.port);
                errors++;
            end
            if (got.index != want.index) begin
                $display("%0t: index expected %h actual %h", $time, want.index, got.index);
                errors++;
            end
            if (got.value != want.value) begin
                $display("%0t: value expected %h actual %h", $time, want.value, got.value);
                errors++;
            end
            if (got.last != want.last) begin
                $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_cmd = rfbs_pkg::CMD_ARRIVE;
    logic [1:0]  s_src_port = '0;
    logic [31:0] s_pkt_index = '0;
    logic [31:0] s_pkt_value = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_out_kind;
    logic [1:0]  m_out_port;
    logic [31:0] m_out_index;
    logic [31:0] m_out_value;
    logic        m_last;

    switch_scoreboard sb = new();
    int tx_idle_pct = 32;
    int rx_idle_pct = 52;
    int rx_hold_req = 0;
    int rx_hold_cnt = 0;
    int stall_cycles = 0;

    always #1 aclk = ~aclk;

    radix_four_bucket_switch_top u_top (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd),
        .s_src_port(s_src_port), .s_pkt_index(s_pkt_index), .s_pkt_value(s_pkt_value),
        .m_valid(m_valid), .m_ready(m_ready), .m_out_kind(m_out_kind),
        .m_out_port(m_out_port), .m_out_index(m_out_index),
        .m_out_value(m_out_value), .m_last(m_last)
    );

    always @(posedge aclk) begin
        rfbs_pkg::result_t got;
        if (m_valid && m_ready) begin
            got.kind  = m_out_kind;
            got.port  = m_out_port;
            got.index = m_out_index;
            got.value = m_out_value;
            got.last  = m_last;
            sb.check_result(got);
        end
        if (rx_hold_cnt == 0 && rx_hold_req != 0) begin
            rx_hold_cnt = rx_hold_req;
            rx_hold_req = 0;
        end
        if (rx_hold_cnt > 0) begin
            rx_hold_cnt--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= 3000) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_item(bit cmd, bit [1:0] src, bit [31:0] idx, bit [31:0] val);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_cmd       <= cmd;
        s_src_port  <= src;
        s_pkt_index <= idx;
        s_pkt_value <= val;
        do @(posedge aclk); while (!s_ready);
        sb.note_item(cmd, src, idx, val);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (sb.expected_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_digit_select(bit [3:0] ds);
        wait_drained();
        repeat (10) @(posedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= 2'(4 * rfbs_pkg::REG_DIGIT_SELECT);
        pwdata  <= {28'd0, ds};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata[3:0] != ds) begin
            $display("%0t: digit_select readback expected %h actual %h", $time, ds, prdata);
            sb.errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.digit_sel = ds;
        @(posedge aclk);
    endtask

    // finish every source, then send ticks, at most 60, until one yields the end markers
    task automatic close_run();
        int ends0;
        ends0 = sb.n_end_markers;
        for (int s = 0; s < 4; s++) send_item(rfbs_pkg::CMD_ARRIVE, 2'(s), $urandom, 32'd0);
        for (int k = 0; k < 60 && sb.n_end_markers == ends0; k++)
            send_item(rfbs_pkg::CMD_TICK, 2'($urandom), $urandom, $urandom);
    endtask

    task automatic random_run(int n);
        int r;
        bit [31:0] v;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99);
            v = $urandom;
            if (r < 12) begin
                if ($urandom_range(3) == 0) v = 0;
                send_item(1'($urandom), 2'($urandom), $urandom, v);
            end else if (r < 45) begin
                send_item(rfbs_pkg::CMD_TICK, 2'($urandom), $urandom, $urandom);
            end else begin
                if (v == 0) v = 1;
                send_item(rfbs_pkg::CMD_ARRIVE, 2'($urandom), $urandom, v);
            end
        end
        if ($urandom_range(3) != 0) close_run();
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_digit_select(4'd0);

        send_item(rfbs_pkg::CMD_ARRIVE, 2'd0, 32'h0000_0000, 32'hFFFF_FFFF);
        send_item(rfbs_pkg::CMD_ARRIVE, 2'd1, 32'hFFFF_FFFF, 32'h0000_0001);
        for (int k = 0; k < 5; k++)
            send_item(rfbs_pkg::CMD_ARRIVE, 2'd2, 32'h1, 32'h8000_0000 + 32'(k));
        send_item(rfbs_pkg::CMD_ARRIVE, 2'd2, 32'h1, 32'h5555_5555);
        send_item(rfbs_pkg::CMD_TICK, 2'd0, 32'd0, 32'd0);
        send_item(rfbs_pkg::CMD_ARRIVE, 2'd3, 32'hAAAA_AAAA, 32'd0);
        send_item(rfbs_pkg::CMD_ARRIVE, 2'd3, 32'h5555_5555, 32'h1234_5678);
        send_item(rfbs_pkg::CMD_TICK, 2'd0, 32'd0, 32'd0);
        close_run();
        send_item(rfbs_pkg::CMD_TICK, 2'd0, 32'd0, 32'd0);

        write_digit_select(4'd15);
        random_run(40);
        rx_hold_req = 150;
        random_run(30);
        wait_drained();
        random_run(20);

        tx_idle_pct = 52;
        rx_idle_pct = 32;
        write_digit_select(4'd5);
        random_run(50);
        write_digit_select(4'd1);
        random_run(40);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_digit_select(4'd10);
        random_run(50);
        close_run();

        wait_drained();
        repeat (20) @(posedge aclk);
        $display("Covered %0d items over digit selects 0,15,5,1,10: %0d deliveries,",
                 sb.n_items, sb.n_delivered);
        $display("%0d end-marker ticks, %0d held and %0d rejected arrivals.",
                 sb.n_end_markers, sb.n_held, sb.n_rejected);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
